[hdl/vmag_pkg.sv]
`timescale 1ns / 1ps

package vmag_pkg;

    // Field widths of one transaction
    localparam int KIND_W    = 3;
    localparam int ADDR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int LINE_W    = 9;
    localparam int DOT_W     = 11;
    localparam int SPR_IDX_W = 10;

    // Fixed memory sizes
    localparam int SPRITE_BYTES  = 544;
    localparam int PALETTE_BYTES = 512;
    localparam int SPRITE_AW     = $clog2(SPRITE_BYTES);
    localparam int PALETTE_AW    = $clog2(PALETTE_BYTES);

    // Display timing and address folding constants
    localparam logic [LINE_W-1:0]     LINE_LIMIT_SHORT = 9'd225;
    localparam logic [LINE_W-1:0]     LINE_LIMIT_TALL  = 9'd240;
    localparam logic [SPR_IDX_W-1:0]  SPRITE_ADDR_MASK = 10'h3ff;
    localparam logic [SPR_IDX_W-1:0]  SPRITE_HI_BIT    = 10'h200;
    localparam logic [SPR_IDX_W-1:0]  SPRITE_HI_MASK   = 10'h21f;
    localparam logic [PALETTE_AW-1:0] PALETTE_MASK     = 9'h1ff;
    localparam logic [BYTE_W-1:0]     PALETTE_ODD_MASK = 8'h7f;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCED_BLANK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TALL_PICTURE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WRITES = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_VIDEO_READ    = 3'd0,
        KIND_VIDEO_WRITE   = 3'd1,
        KIND_SPRITE_READ   = 3'd2,
        KIND_SPRITE_WRITE  = 3'd3,
        KIND_PALETTE_READ  = 3'd4,
        KIND_PALETTE_WRITE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_VIDEO,
        RD_SPRITE,
        RD_PALETTE
    } rd_sel_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ADDR_W-1:0]    address;
        logic [BYTE_W-1:0]    write_data;
        logic [LINE_W-1:0]    line_now;
        logic [LINE_W-1:0]    line_ahead;
        logic [LINE_W-1:0]    line_behind;
        logic [DOT_W-1:0]     dot_behind;
        logic [BYTE_W-1:0]    bus_latch;
        logic [SPR_IDX_W-1:0] sprite_internal_addr;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              stored;
    } out_item_t;

    // Memory access decided for one transaction
    typedef struct packed {
        logic    vid_en;
        logic    vid_we;
        logic    spr_en;
        logic    spr_we;
        logic    pal_en;
        logic    pal_we;
        logic    stored;
        rd_sel_t rd_sel;
        logic    mask7;
    } acc_t;

endpackage

[hdl/vmag_ram.sv]
`timescale 1ns / 1ps

module vmag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data only changes on a read, so it holds while the result stalls
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/vmag_decode.sv]
`timescale 1ns / 1ps

module vmag_decode #(
    parameter int VIDEO_BYTES = 65536
) (
    input  vmag_pkg::in_item_t               item,
    input  logic                             forced_blank,
    input  logic                             tall_picture,
    input  logic                             block_writes,
    output vmag_pkg::acc_t                   acc,
    output logic [$clog2(VIDEO_BYTES)-1:0]   vid_addr,
    output logic [vmag_pkg::SPRITE_AW-1:0]   spr_addr,
    output logic [vmag_pkg::PALETTE_AW-1:0]  pal_addr,
    output logic [vmag_pkg::BYTE_W-1:0]      wdata
);

    localparam int VA_W   = $clog2(VIDEO_BYTES);
    localparam int SPAN   = 1 << vmag_pkg::ADDR_W;
    localparam int MAX_Q  = (SPAN - 1) / VIDEO_BYTES;
    localparam int QSTEPS = $clog2(MAX_Q + 1);

    logic [vmag_pkg::ADDR_W:0]      vid_rem;
    logic [vmag_pkg::LINE_W-1:0]    line_limit;
    logic                           act_now;
    logic                           act_ahead;
    logic                           act_behind;
    logic [vmag_pkg::SPR_IDX_W-1:0] spr_src;
    logic [vmag_pkg::SPR_IDX_W-1:0] spr_fold;

    assign line_limit = tall_picture ? vmag_pkg::LINE_LIMIT_TALL : vmag_pkg::LINE_LIMIT_SHORT;
    assign act_now    = !forced_blank && (item.line_now < line_limit);
    assign act_ahead  = !forced_blank && (item.line_ahead < line_limit);
    assign act_behind = !forced_blank && (item.line_behind < line_limit);

    // Reduce the address modulo the video size: one compare and subtract per quotient bit
    always_comb begin
        vid_rem = {1'b0, item.address};
        for (int k = QSTEPS - 1; k >= 0; k--) begin
            if (vid_rem >= ((vmag_pkg::ADDR_W + 1)'(VIDEO_BYTES) << k)) begin
                vid_rem = vid_rem - ((vmag_pkg::ADDR_W + 1)'(VIDEO_BYTES) << k);
            end
        end
    end
    assign vid_addr = vid_rem[VA_W-1:0];

    // Fold sprite address into 544 bytes
    assign spr_src  = act_now ? item.sprite_internal_addr
                              : item.address[vmag_pkg::SPR_IDX_W-1:0];
    always_comb begin
        spr_fold = spr_src & vmag_pkg::SPRITE_ADDR_MASK;
        if ((spr_fold & vmag_pkg::SPRITE_HI_BIT) != '0) begin
            spr_fold = spr_fold & vmag_pkg::SPRITE_HI_MASK;
        end
    end
    assign spr_addr = spr_fold[vmag_pkg::SPRITE_AW-1:0];

    assign pal_addr = item.address[vmag_pkg::PALETTE_AW-1:0] & vmag_pkg::PALETTE_MASK;

    always_comb begin
        acc       = '0;
        acc.rd_sel = vmag_pkg::RD_NONE;
        wdata     = item.write_data;
        unique case (vmag_pkg::kind_t'(item.kind))
            vmag_pkg::KIND_VIDEO_READ: begin
                if (!act_ahead) begin
                    acc.vid_en = 1'b1;
                    acc.rd_sel = vmag_pkg::RD_VIDEO;
                end
            end
            vmag_pkg::KIND_VIDEO_WRITE: begin
                if (!block_writes || !act_behind) begin
                    acc.vid_en = 1'b1;
                    acc.vid_we = 1'b1;
                    acc.stored = 1'b1;
                end else if (item.line_behind == '0 && item.dot_behind == '0) begin
                    // First dot of line zero: the open bus byte lands in memory
                    acc.vid_en = 1'b1;
                    acc.vid_we = 1'b1;
                    acc.stored = 1'b1;
                    wdata      = item.bus_latch;
                end
            end
            vmag_pkg::KIND_SPRITE_READ: begin
                acc.spr_en = 1'b1;
                acc.rd_sel = vmag_pkg::RD_SPRITE;
            end
            vmag_pkg::KIND_SPRITE_WRITE: begin
                acc.spr_en = 1'b1;
                acc.spr_we = 1'b1;
                acc.stored = 1'b1;
            end
            vmag_pkg::KIND_PALETTE_READ: begin
                acc.pal_en = 1'b1;
                acc.rd_sel = vmag_pkg::RD_PALETTE;
                acc.mask7  = pal_addr[0];
            end
            vmag_pkg::KIND_PALETTE_WRITE: begin
                acc.pal_en = 1'b1;
                acc.pal_we = 1'b1;
                acc.stored = 1'b1;
                if (pal_addr[0]) begin
                    wdata = item.write_data & vmag_pkg::PALETTE_ODD_MASK;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/video_memory_access_gate_core.sv]
`timescale 1ns / 1ps

// Video memory access gate. Each input transaction is one CPU access to video,
// sprite or palette memory; each produces exactly one result transaction with
// the byte read and a flag telling whether a write reached memory. The block
// takes one transaction per clock while the result is not stalled. Each one
// waits in the input register while the access is decoded, then passes
// through the registered read of the selected memory to the result. A stalled result
// holds the memory read data in place, and the input register keeps accepting
// until it is itself full. No clearing pass after reset: memories hold
// undefined data until written, and reading an unwritten byte returns
// whatever the RAM holds. Configuration is written through cfg_we/cfg_index/
// cfg_wdata (index 0 forced blank, 1 tall picture, 2 block bad video writes)
// and must only change while no transaction is in flight.

module video_memory_access_gate_core #(
    parameter int VIDEO_BYTES = 65536
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  vmag_pkg::in_item_t                s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output vmag_pkg::out_item_t               m_data,

    input  logic                              cfg_we,
    input  logic [vmag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [0:0]                        cfg_wdata
);

    localparam int VA_W = $clog2(VIDEO_BYTES);

    // Configuration
    logic forced_blank_reg, forced_blank_next;
    logic tall_picture_reg, tall_picture_next;
    logic block_writes_reg, block_writes_next;

    // Input stage
    logic               a_valid_reg, a_valid_next;
    vmag_pkg::in_item_t a_item_reg;

    // Result stage, aligned with the RAM read data
    logic              b_valid_reg, b_valid_next;
    vmag_pkg::rd_sel_t b_sel_reg;
    logic              b_mask_reg;
    logic              b_stored_reg;

    logic advance;

    vmag_pkg::acc_t                  acc;
    logic [VA_W-1:0]                 vid_addr;
    logic [vmag_pkg::SPRITE_AW-1:0]  spr_addr;
    logic [vmag_pkg::PALETTE_AW-1:0] pal_addr;
    logic [vmag_pkg::BYTE_W-1:0]     wdata;

    logic                            vid_en, spr_en, pal_en;
    logic [vmag_pkg::BYTE_W-1:0]     vid_rdata, spr_rdata, pal_rdata;
    logic [vmag_pkg::BYTE_W-1:0]     rd_byte;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_comb begin
        forced_blank_next = forced_blank_reg;
        tall_picture_next = tall_picture_reg;
        block_writes_next = block_writes_reg;
        if (cfg_we) begin
            if (cfg_index == vmag_pkg::CFG_FORCED_BLANK) begin
                forced_blank_next = cfg_wdata[0];
            end
            if (cfg_index == vmag_pkg::CFG_TALL_PICTURE) begin
                tall_picture_next = cfg_wdata[0];
            end
            if (cfg_index == vmag_pkg::CFG_BLOCK_WRITES) begin
                block_writes_next = cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forced_blank_reg <= 1'b1;
            tall_picture_reg <= 1'b0;
            block_writes_reg <= 1'b1;
        end else begin
            forced_blank_reg <= forced_blank_next;
            tall_picture_reg <= tall_picture_next;
            block_writes_reg <= block_writes_next;
        end
    end

    // ---------------------------------------------------------------
    // Handshake: advance the input stage whenever the result slot is
    // free or being emptied this cycle
    // ---------------------------------------------------------------
    assign advance = a_valid_reg && (!b_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || advance;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_valid && s_ready) begin
            a_valid_next = 1'b1;
        end else if (advance) begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (advance) begin
            b_valid_next = 1'b1;
        end else if (m_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Hold payload registers until the stage moves
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_item_reg <= s_data;
        end
        if (advance) begin
            b_sel_reg    <= acc.rd_sel;
            b_mask_reg   <= acc.mask7;
            b_stored_reg <= acc.stored;
        end
    end

    // ---------------------------------------------------------------
    // Access decode: timing rules and address folding
    // ---------------------------------------------------------------
    vmag_decode #(
        .VIDEO_BYTES (VIDEO_BYTES)
    ) u_decode (
        .item         (a_item_reg),
        .forced_blank (forced_blank_reg),
        .tall_picture (tall_picture_reg),
        .block_writes (block_writes_reg),
        .acc          (acc),
        .vid_addr     (vid_addr),
        .spr_addr     (spr_addr),
        .pal_addr     (pal_addr),
        .wdata        (wdata)
    );

    // Issue the memory access only when the transaction moves on, so a
    // stalled result keeps its read data
    assign vid_en = acc.vid_en && advance;
    assign spr_en = acc.spr_en && advance;
    assign pal_en = acc.pal_en && advance;

    vmag_ram #(
        .WIDTH (vmag_pkg::BYTE_W),
        .DEPTH (VIDEO_BYTES)
    ) u_video_ram (
        .aclk  (aclk),
        .en    (vid_en),
        .we    (acc.vid_we),
        .addr  (vid_addr),
        .wdata (wdata),
        .rdata (vid_rdata)
    );

    vmag_ram #(
        .WIDTH (vmag_pkg::BYTE_W),
        .DEPTH (vmag_pkg::SPRITE_BYTES)
    ) u_sprite_ram (
        .aclk  (aclk),
        .en    (spr_en),
        .we    (acc.spr_we),
        .addr  (spr_addr),
        .wdata (wdata),
        .rdata (spr_rdata)
    );

    vmag_ram #(
        .WIDTH (vmag_pkg::BYTE_W),
        .DEPTH (vmag_pkg::PALETTE_BYTES)
    ) u_palette_ram (
        .aclk  (aclk),
        .en    (pal_en),
        .we    (acc.pal_we),
        .addr  (pal_addr),
        .wdata (wdata),
        .rdata (pal_rdata)
    );

    // ---------------------------------------------------------------
    // Result: select the memory that was read, drop blocked reads to zero
    // ---------------------------------------------------------------
    always_comb begin
        unique case (b_sel_reg)
            vmag_pkg::RD_NONE:    rd_byte = '0;
            vmag_pkg::RD_VIDEO:   rd_byte = vid_rdata;
            vmag_pkg::RD_SPRITE:  rd_byte = spr_rdata;
            vmag_pkg::RD_PALETTE: rd_byte = pal_rdata;
            // Select is unset until the first transaction reaches the result stage
            default:              rd_byte = '0;
        endcase
        if (b_mask_reg) begin
            rd_byte = rd_byte & vmag_pkg::PALETTE_ODD_MASK;
        end
    end

    assign m_valid          = b_valid_reg;
    assign m_data.read_data = rd_byte;
    assign m_data.stored    = b_stored_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_one_memory: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({vid_en, spr_en, pal_en}))
        else $error("more than one memory accessed in a cycle");

    a_no_read_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !m_ready) |-> !(vid_en || spr_en || pal_en))
        else $error("memory accessed while the result is stalled");

    a_write_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_stored_reg) |-> (b_sel_reg == vmag_pkg::RD_NONE))
        else $error("result marked stored but selects read data");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> b_valid_reg)
        else $error("advanced transaction missing in result stage");

endmodule
